// ===== rtl/bvlm_pkg.sv =====
// ----------------------------------------------------------------------------
// Battery voltage level monitor package
// Widths, register indexes, mapping constants and the bar level table.
// ----------------------------------------------------------------------------
package bvlm_pkg;

   localparam int SAMPLES_DEF = 16;

   localparam int ADC_W   = 12;
   localparam int VOLT_W  = 16;
   localparam int PCT_W   = 7;
   localparam int LVL_W   = 3;
   localparam int SUM_W   = 18;
   localparam int TICK_W  = 16;

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 32;
   localparam int RSP_USER_W = 1;

   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_EMPTY_MV      = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FULL_MV       = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VOLT_OFFSET   = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_PERIOD = 8'd3;

   localparam logic [VOLT_W-1:0] EMPTY_MV_RST      = 16'd3600;
   localparam logic [VOLT_W-1:0] FULL_MV_RST       = 16'd4200;
   localparam logic [VOLT_W-1:0] VOLT_OFFSET_RST   = 16'd0;
   localparam logic [TICK_W-1:0] SAMPLE_PERIOD_RST = 16'd62;

   localparam int IN_LOW  = 2720;
   localparam int IN_HIGH = 3310;
   localparam int IN_SPAN = IN_HIGH - IN_LOW;

   localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

   // serial divider sizing
   localparam int NUM_W = 29;
   localparam int DEN_W = 16;
   localparam int CNT_W = $clog2(NUM_W);

   localparam int DELTA_W = ADC_W + 1;
   localparam int RISE_W  = VOLT_W + 1;
   localparam int PROD_W  = DELTA_W + RISE_W;

   function automatic logic [LVL_W-1:0] level_of(input logic [PCT_W-1:0] pct);
      logic [LVL_W-1:0] lvl;
      if (pct > 7'd90) begin
         lvl = 3'd7;
      end else if (pct > 7'd78) begin
         lvl = 3'd6;
      end else if (pct > 7'd66) begin
         lvl = 3'd5;
      end else if (pct > 7'd54) begin
         lvl = 3'd4;
      end else if (pct > 7'd42) begin
         lvl = 3'd3;
      end else if (pct > 7'd30) begin
         lvl = 3'd2;
      end else if (pct >= 7'd10) begin
         lvl = 3'd1;
      end else begin
         lvl = 3'd0;
      end
      return lvl;
   endfunction

endpackage

// ===== rtl/battery_voltage_level_monitor.sv =====
// ----------------------------------------------------------------------------
// Battery voltage level monitor
// Tick-driven fuel gauge: averaging, linear mapping, percentage and bar level.
// ----------------------------------------------------------------------------
// Each req transfer is one millisecond tick carrying the converter reading and
// the charge pin; each tick yields exactly one rsp transfer with the voltage,
// percentage, bar level, charge and low-battery flags, and in tuser a flag that
// marks a freshly completed average. The csr channel writes the empty and full
// voltages, volt_offset and sample_period (indexes 0 to 3) and drops other
// indexes; write it only while no tick is in flight.
// One tick is handled at a time. After the req transfer the serial divider
// computes the percentage, and rsp_tvalid rises and req_tready returns in
// the same cycle; a percentage that is zero by range skips the divider pass.
// A tick that completes an average adds two divider passes (sum by SAMPLES,
// product by 590) and a multiply stage before the percentage pass.
// req_tready is high only while the block is idle; the result sits in an
// output register, so the next tick is taken while rsp waits, and the result
// after it holds back until rsp drains. Reset clears counters, accumulator
// and mapped voltage and loads the register defaults.
// ----------------------------------------------------------------------------
module battery_voltage_level_monitor
   import bvlm_pkg::*;
#(
   parameter int SAMPLES = SAMPLES_DEF
)(
   input  logic                  clock,
   input  logic                  reset,
   // adc_sample [11:0], charge_pin [12]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // voltage_mv [15:0], percentage [22:16], level [25:23],
   // is_charging [26], low_battery [27]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // updated [0]
   output logic [RSP_USER_W-1:0] rsp_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int IDX_W = $clog2(SAMPLES + 1);

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_AVG   = 8'b0000_0010,
      ST_MUL   = 8'b0000_0100,
      ST_SGO   = 8'b0000_1000,
      ST_SCALE = 8'b0001_0000,
      ST_PGO   = 8'b0010_0000,
      ST_PCT   = 8'b0100_0000,
      ST_DONE  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [VOLT_W-1:0] empty_mv_ff, full_mv_ff, volt_offset_ff;
   logic [TICK_W-1:0] sample_period_ff;

   logic [TICK_W-1:0] tick_ff, tick_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [VOLT_W-1:0] mapped_ff, mapped_in;
   logic [PCT_W-1:0]  pct_ff, pct_in;
   logic              pin_ff, pin_in;
   logic              updated_ff, updated_in;

   logic signed [DELTA_W-1:0] delta_ff, delta_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [RSP_USER_W-1:0] rsp_user_ff, rsp_user_in;

   logic             div_start;
   logic [NUM_W-1:0] div_num;
   logic [DEN_W-1:0] div_den;
   logic             div_done;
   logic [NUM_W-1:0] div_quo;

   logic                 req_xfer;
   logic [ADC_W-1:0]     adc;
   logic [TICK_W-1:0]    tick_inc;
   logic                 take;
   logic [SUM_W-1:0]     sum_add;
   logic [IDX_W-1:0]     idx_add;
   logic                 avg_due;

   logic signed [RISE_W-1:0] rise;
   logic [PROD_W-1:0]        prod_mag;
   logic                     prod_neg;
   logic [VOLT_W-1:0]        q16;
   logic [VOLT_W-1:0]        volts;
   logic [VOLT_W-1:0]        pdiff;
   logic [NUM_W-1:0]         pnum;
   logic                     pct_run;
   logic [VOLT_W-1:0]        span;
   logic                     low_batt;

   bvlm_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid & req_tready;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         empty_mv_ff      <= EMPTY_MV_RST;
         full_mv_ff       <= FULL_MV_RST;
         volt_offset_ff   <= VOLT_OFFSET_RST;
         sample_period_ff <= SAMPLE_PERIOD_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_EMPTY_MV:      empty_mv_ff      <= csr_wdata;
            CSR_FULL_MV:       full_mv_ff       <= csr_wdata;
            CSR_VOLT_OFFSET:   volt_offset_ff   <= csr_wdata;
            CSR_SAMPLE_PERIOD: sample_period_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      adc      = req_tdata[ADC_W-1:0];
      tick_inc = (tick_ff == '1) ? tick_ff : tick_ff + 1'b1;
      take     = tick_inc > sample_period_ff;
      sum_add  = sum_ff + SUM_W'(adc);
      idx_add  = idx_ff + 1'b1;
      avg_due  = take && (idx_add >= IDX_W'(SAMPLES));

      rise     = RISE_W'({1'b0, full_mv_ff}) - RISE_W'({1'b0, empty_mv_ff});
      prod_neg = prod_ff[PROD_W-1];
      prod_mag = prod_neg ? PROD_W'(-prod_ff) : PROD_W'(prod_ff);
      q16      = div_quo[VOLT_W-1:0];

      volts    = mapped_ff + volt_offset_ff;
      span     = full_mv_ff - empty_mv_ff;
      pct_run  = (full_mv_ff > empty_mv_ff) && (volts > empty_mv_ff);
      pdiff    = volts - empty_mv_ff;
      pnum     = (NUM_W'(pdiff) << 6) + (NUM_W'(pdiff) << 5) + (NUM_W'(pdiff) << 2);
      low_batt = pin_ff && (volts < empty_mv_ff);
   end

   always_comb begin
      div_start = 1'b0;
      div_num   = NUM_W'(sum_add);
      div_den   = DEN_W'(SAMPLES);
      if (req_xfer && avg_due) begin
         div_start = 1'b1;
      end else if (state_ff == ST_SGO) begin
         div_start = 1'b1;
         div_num   = prod_mag[NUM_W-1:0];
         div_den   = DEN_W'(IN_SPAN);
      end else if (state_ff == ST_PGO) begin
         div_start = pct_run;
         div_num   = pnum;
         div_den   = span;
      end
   end

   always_comb begin
      state_in     = state_ff;
      tick_in      = tick_ff;
      sum_in       = sum_ff;
      idx_in       = idx_ff;
      mapped_in    = mapped_ff;
      pct_in       = pct_ff;
      pin_in       = pin_ff;
      updated_in   = updated_ff;
      delta_in     = delta_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               pin_in     = req_tdata[ADC_W];
               updated_in = avg_due;
               tick_in    = take ? '0 : tick_inc;
               if (avg_due) begin
                  sum_in   = '0;
                  idx_in   = '0;
                  state_in = ST_AVG;
               end else begin
                  if (take) begin
                     sum_in = sum_add;
                     idx_in = idx_add;
                  end
                  state_in = ST_PGO;
               end
            end
         end
         ST_AVG: begin
            if (div_done) begin
               delta_in = DELTA_W'({1'b0, div_quo[ADC_W-1:0]}) - DELTA_W'(IN_LOW);
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = PROD_W'(delta_ff) * PROD_W'(rise);
            state_in = ST_SGO;
         end
         ST_SGO: begin
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            if (div_done) begin
               mapped_in = (prod_neg ? (VOLT_W'(0) - q16) : q16) + empty_mv_ff;
               state_in  = ST_PGO;
            end
         end
         ST_PGO: begin
            if (pct_run) begin
               state_in = ST_PCT;
            end else begin
               pct_in   = '0;
               state_in = ST_DONE;
            end
         end
         ST_PCT: begin
            if (div_done) begin
               pct_in   = (div_quo > NUM_W'(PCT_FULL)) ? PCT_FULL : div_quo[PCT_W-1:0];
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_W'({low_batt, ~pin_ff, level_of(pct_ff),
                                           pct_ff, volts});
               rsp_user_in  = updated_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tick_ff      <= '0;
         sum_ff       <= '0;
         idx_ff       <= '0;
         mapped_ff    <= '0;
         pct_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tick_ff      <= tick_in;
         sum_ff       <= sum_in;
         idx_ff       <= idx_in;
         mapped_ff    <= mapped_in;
         pct_ff       <= pct_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pin_ff      <= pin_in;
      updated_ff  <= updated_in;
      delta_ff    <= delta_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ===== rtl/bvlm_div.sv =====
// ----------------------------------------------------------------------------
// Bit-serial unsigned divider
// Restoring long division, one quotient bit per cycle, a NUM_W-bit quotient a run.
// ----------------------------------------------------------------------------
module bvlm_div
   import bvlm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quo
);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;

   logic [DEN_W:0]   shifted;
   logic [DEN_W+1:0] trial;
   logic             fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[NUM_W-1]};
      trial   = {1'b0, shifted} - {2'b00, den_ff};
      fits    = ~trial[DEN_W+1];

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;

      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W - 1);
         quo_in  = num;
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         quo_in = {quo_ff[NUM_W-2:0], fits};
         rem_in = fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Battery voltage level monitor testbench
// Drives millisecond ticks carrying converter readings and the charge pin,
// tracks averaging, linear mapping, percentage and bar level in a local model
// and compares every result transfer field by field. Both streams stall at
// random, the receiver holds off once for a long stretch, and the register
// settings change between phases, extremes included.
// ----------------------------------------------------------------------------
module tb;
   import bvlm_pkg::*;

   localparam int SAMPLES       = SAMPLES_DEF;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int RANDOM_PHASES = 8;

   typedef struct packed {
      logic [VOLT_W-1:0] volts;
      logic [PCT_W-1:0]  pct;
      logic [LVL_W-1:0]  bars;
      logic              charging;
      logic              low_batt;
      logic              fresh;
   } reading_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   // gauge registers and state as the block should hold them
   logic [VOLT_W-1:0] min_mv       = EMPTY_MV_RST;
   logic [VOLT_W-1:0] max_mv       = FULL_MV_RST;
   logic [VOLT_W-1:0] offset_mv    = VOLT_OFFSET_RST;
   logic [TICK_W-1:0] period_ticks = SAMPLE_PERIOD_RST;
   logic [TICK_W-1:0] tick_cnt     = '0;
   logic [SUM_W-1:0]  acc_sum      = '0;
   logic [6:0]        acc_count    = '0;
   logic [VOLT_W-1:0] held_mv      = '0;

   reading_type pending_readings[$];
   int          mismatch_count = 0;
   int          cycle_count    = 0;
   bit          idle_on        = 1'b1;
   int          hold_request   = 0;

   battery_voltage_level_monitor #(
      .SAMPLES (SAMPLES)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

   function automatic logic [LVL_W-1:0] bar_level(input int pct);
      int steps[6] = '{30, 42, 54, 66, 78, 90};
      int bars;
      bars = (pct >= 10) ? 1 : 0;
      foreach (steps[i]) begin
         if (pct > steps[i]) begin
            bars++;
         end
      end
      return bars[LVL_W-1:0];
   endfunction

   function automatic int percent_of_mv(input logic [VOLT_W-1:0] volts);
      longint span;
      longint p;
      if (max_mv <= min_mv) begin
         return 0;
      end
      span = longint'(max_mv) - longint'(min_mv);
      p = ((longint'(volts) - longint'(min_mv)) * 100) / span;
      if (p < 0) begin
         p = 0;
      end else if (p > 100) begin
         p = 100;
      end
      return int'(p);
   endfunction

   // advance the gauge by one tick and queue the reading it should report
   function automatic void gauge_tick(input logic [ADC_W-1:0] adc, input logic pin);
      reading_type r;
      longint      delta;
      longint      rise;
      longint      mapped;
      int          pct;
      r.fresh = 1'b0;
      if (tick_cnt != '1) begin
         tick_cnt++;
      end
      if (tick_cnt > period_ticks) begin
         tick_cnt  = '0;
         acc_sum   = acc_sum + SUM_W'(adc);
         acc_count = acc_count + 1'b1;
         if (acc_count >= SAMPLES) begin
            delta   = longint'(acc_sum / SAMPLES) - IN_LOW;
            rise    = longint'(max_mv) - longint'(min_mv);
            mapped  = (delta * rise) / IN_SPAN + longint'(min_mv);
            held_mv = mapped[VOLT_W-1:0];
            acc_sum   = '0;
            acc_count = '0;
            r.fresh   = 1'b1;
         end
      end
      r.volts    = held_mv + offset_mv;
      pct        = percent_of_mv(r.volts);
      r.pct      = pct[PCT_W-1:0];
      r.bars     = bar_level(pct);
      r.charging = ~pin;
      r.low_batt = pin && (r.volts < min_mv);
      pending_readings.push_back(r);
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      reading_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_readings.size() == 0) begin
            $error("result transfer with no tick outstanding: tdata %h", rsp_tdata);
            mismatch_count++;
         end else begin
            want = pending_readings.pop_front();
            check_field("voltage_mv", 32'(want.volts), 32'(rsp_tdata[15:0]));
            check_field("percentage", 32'(want.pct), 32'(rsp_tdata[22:16]));
            check_field("level", 32'(want.bars), 32'(rsp_tdata[25:23]));
            check_field("is_charging", 32'(want.charging), 32'(rsp_tdata[26]));
            check_field("low_battery", 32'(want.low_batt), 32'(rsp_tdata[27]));
            check_field("updated", 32'(want.fresh), 32'(rsp_tuser[0]));
         end
      end
   end

   initial begin : receiver
      int n;
      while (reset) @(posedge clock);
      forever begin
         if (hold_request != 0) begin
            n = hold_request;
            hold_request = 0;
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
      end
   end

   task automatic send_tick(input logic [ADC_W-1:0] adc, input logic pin);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_tdata  <= REQ_DATA_W'({pin, adc});
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      gauge_tick(adc, pin);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // leaves csr_valid high; the caller drops it after its last write
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_index <= idx;
      csr_wdata <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_EMPTY_MV:      min_mv       = value;
         CSR_FULL_MV:       max_mv       = value;
         CSR_VOLT_OFFSET:   offset_mv    = value;
         CSR_SAMPLE_PERIOD: period_ticks = value;
         default: ;
      endcase
   endtask

   task automatic configure_gauge(input logic [VOLT_W-1:0] lo, input logic [VOLT_W-1:0] hi,
                                  input logic [VOLT_W-1:0] offs,
                                  input logic [TICK_W-1:0] per);
      wait_idle();
      write_reg(CSR_EMPTY_MV, lo);
      write_reg(CSR_FULL_MV, hi);
      write_reg(CSR_VOLT_OFFSET, offs);
      write_reg(CSR_SAMPLE_PERIOD, per);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [VOLT_W-1:0] pick_volt();
      logic [VOLT_W-1:0] v;
      case ($urandom_range(0, 5))
         0:       v = '0;
         1:       v = '1;
         2, 3:    v = VOLT_W'($urandom_range(3000, 4500));
         default: v = VOLT_W'($urandom);
      endcase
      return v;
   endfunction

   function automatic logic [ADC_W-1:0] pick_adc(input int center);
      int v;
      case ($urandom_range(0, 9))
         0:       v = $urandom_range(0, 4095);
         1:       v = $urandom_range(0, 1) ? 4095 : 0;
         default: v = center + int'($urandom_range(0, 40)) - 20;
      endcase
      if (v < 0) begin
         v = 0;
      end else if (v > 4095) begin
         v = 4095;
      end
      return v[ADC_W-1:0];
   endfunction

   task automatic random_config();
      logic [VOLT_W-1:0] lo;
      logic [VOLT_W-1:0] hi;
      logic [VOLT_W-1:0] offs;
      logic [TICK_W-1:0] per;
      lo = pick_volt();
      hi = ($urandom_range(0, 5) == 0) ? lo : pick_volt();
      case ($urandom_range(0, 4))
         0, 1:    offs = '0;
         2:       offs = VOLT_W'($urandom_range(0, 200));
         3:       offs = '1;
         default: offs = VOLT_W'($urandom);
      endcase
      case ($urandom_range(0, 7))
         0, 1, 2, 3, 4: per = '0;
         5:             per = TICK_W'(1);
         6:             per = TICK_W'($urandom_range(2, 8));
         default:       per = ($urandom_range(0, 3) == 0) ? '1
                                                          : TICK_W'($urandom_range(9, 40));
      endcase
      configure_gauge(lo, hi, offs, per);
   endtask

   task automatic random_ticks(input int count);
      int   center;
      logic pin_level;
      center    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                             : $urandom_range(2650, 3380);
      pin_level = 1'($urandom_range(0, 1));
      repeat (count) begin
         send_tick(pick_adc(center),
                   ($urandom_range(0, 7) == 0) ? ~pin_level : pin_level);
      end
   endtask

   task automatic test_reset_defaults();
      send_tick(12'hFFF, 1'b1);
      send_tick(12'h000, 1'b0);
   endtask

   task automatic test_full_scale_average();
      configure_gauge(16'd3600, 16'd4200, 16'd0, 16'd0);
      for (int i = 0; i < SAMPLES; i++) begin
         send_tick(12'hFFF, i[0]);
      end
   endtask

   task automatic test_live_registers();
      configure_gauge(16'd3600, 16'd4200, 16'hFFFF, 16'd0);
      send_tick(12'h000, 1'b1);
      configure_gauge(16'd4000, 16'd4000, 16'd0, 16'd0);
      send_tick(12'hAAA, 1'b1);
      configure_gauge(16'hFFFF, 16'd0, 16'd0, 16'd0);
      send_tick(12'h555, 1'b1);
      configure_gauge(16'd6000, 16'd7000, 16'd0, 16'd0);
      send_tick(12'h800, 1'b0);
      configure_gauge(16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
      send_tick(12'hFFF, 1'b1);
      send_tick(12'h001, 1'b1);
      // writes to unmapped indexes must leave every register alone
      wait_idle();
      write_reg(8'd4, 16'h1234);
      write_reg('1, 16'hFFFF);
      csr_valid <= 1'b0;
      send_tick(12'h7FF, 1'b1);
   endtask

   task automatic test_random_configs();
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph)
            0:       configure_gauge('0, '1, '0, '0);
            1:       configure_gauge('1, '0, '1, '0);
            default: random_config();
         endcase
         random_ticks(170);
      end
   endtask

   task automatic test_backpressure();
      random_config();
      idle_on = 1'b0;
      hold_request = 600;
      random_ticks(40);
      idle_on = 1'b1;
   endtask

   task automatic test_steady_stream();
      idle_on = 1'b0;
      random_config();
      random_ticks(150);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_full_scale_average();
      test_live_registers();
      test_random_configs();
      test_backpressure();
      test_steady_stream();
      req_tvalid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ===== battery_voltage_level_monitor.f =====
rtl/bvlm_pkg.sv
rtl/bvlm_div.sv
rtl/battery_voltage_level_monitor.sv
bench/tb.sv
